>>> design/epoch_seconds_to_utc_date_defines.svh
// Assertion helpers for the epoch to UTC date converter.
`ifndef EPOCH_SECONDS_TO_UTC_DATE_DEFINES_SVH
`define EPOCH_SECONDS_TO_UTC_DATE_DEFINES_SVH

`define ES2U_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define ES2U_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/es2u_pkg.sv
package es2u_pkg;

    localparam int YEAR_W  = 13;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;

    // seconds per day is 2^7 * 675
    localparam int DAY_LO_BITS = 7;
    localparam int DAY_DIV     = 675;
    localparam int SEC_PER_DAY = 86400;
    // seconds per hour is 2^4 * 225, per minute 2^2 * 15
    localparam int HOUR_DIV    = 225;
    localparam int MIN_DIV     = 15;

    localparam int SHIFT_DAYS     = 719468;
    localparam int DAYS_PER_CYCLE = 146097;
    localparam int DOC_W          = 18;
    localparam logic [DOC_W-1:0] LAST_DOC = 18'd146096;
    // doc / 1460 = (doc / 4) / 365, doc / 36524 = (doc / 4) / 9131
    localparam int DAYS_PER_YEAR  = 365;
    localparam int DAYS_PER_CENT4 = 9131;
    localparam int MP_DIV         = 153;

    localparam logic [YEAR_W-1:0]  YEARS_PER_CYCLE = 13'd400;
    localparam logic [MONTH_W-1:0] MP_JAN          = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_FEB       = 4'd2;

    typedef logic [8:0] doy_t;

    // first day of year (March based) of each month
    function automatic doy_t month_start(input logic [3:0] mp);
        doy_t res;
        case (mp)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd31;
            4'd2:    res = 9'd61;
            4'd3:    res = 9'd92;
            4'd4:    res = 9'd122;
            4'd5:    res = 9'd153;
            4'd6:    res = 9'd184;
            4'd7:    res = 9'd214;
            4'd8:    res = 9'd245;
            4'd9:    res = 9'd275;
            4'd10:   res = 9'd306;
            4'd11:   res = 9'd337;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

>>> design/es2u_dly.sv
module es2u_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [N];

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg[0] <= d;
            for (int i = 1; i < N; i++) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[N-1];

endmodule

>>> design/es2u_cdiv.sv
module es2u_cdiv #(
    parameter int XW      = 16,
    parameter int DIVISOR = 3,
    parameter int QW      = 15,
    parameter int RMW     = 2
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [XW-1:0]  x_i,
    output logic [QW-1:0]  q_o,
    output logic [RMW-1:0] rem_o
);

    localparam longint unsigned RECIP = (64'd1 << XW) / DIVISOR;
    localparam int RW = $clog2(RECIP + 64'd1);
    localparam int PW = XW + RW;
    localparam logic [XW-1:0] DIV_X = XW'(DIVISOR);

    logic [PW-1:0]  prod_reg, prod_next;
    logic [XW-1:0]  x1_reg, x2_reg;
    logic [QW-1:0]  qe_reg, qe_next;
    logic [XW-1:0]  qd_reg, qd_next;
    logic [QW-1:0]  q_reg, q_next;
    logic [RMW-1:0] rem_reg, rem_next;
    logic [XW-1:0]  diff;
    logic           fix;

    // estimate is the quotient or one below it
    assign prod_next = PW'(x_i) * PW'(RECIP);
    assign qe_next   = QW'(prod_reg >> XW);
    assign qd_next   = XW'(XW'(qe_next) * DIV_X);

    assign diff     = x2_reg - qd_reg;
    assign fix      = (diff >= DIV_X);
    assign q_next   = fix ? qe_reg + QW'(1) : qe_reg;
    assign rem_next = fix ? RMW'(diff - DIV_X) : RMW'(diff);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            x1_reg   <= x_i;
            qe_reg   <= qe_next;
            qd_reg   <= qd_next;
            x2_reg   <= x1_reg;
            q_reg    <= q_next;
            rem_reg  <= rem_next;
        end
    end

    assign q_o   = q_reg;
    assign rem_o = rem_reg;

endmodule

>>> design/epoch_seconds_to_utc_date.sv
// Epoch seconds to UTC calendar date and time of day.
// Input channel s_*: one count of seconds since 1970-01-01 00:00:00 UTC per
// transfer, only the low EPOCH_BITS bits are significant.
// Result channel m_*: year, month, day of month, hour, minute and second,
// exactly one result per input transfer, in order.
// Results pass through a chain of constant dividers (days, 400-year cycle,
// century terms, year, month), each a three-stage reciprocal multiply with
// correction.
// Throughput: one transfer per cycle while the receiver takes results.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_ready drops; empty stages inside the pipeline hold as well.
// Reset clears the valid bits only; the data registers are not reset.
// The year wraps modulo 8192 when EPOCH_BITS allows later dates.
`include "epoch_seconds_to_utc_date_defines.svh"

module epoch_seconds_to_utc_date #(
    parameter int EPOCH_BITS = 36
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [EPOCH_BITS-1:0]              s_epoch_seconds,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [es2u_pkg::YEAR_W-1:0]        m_year,
    output logic [es2u_pkg::MONTH_W-1:0]       m_month,
    output logic [es2u_pkg::DAY_W-1:0]         m_day_of_month,
    output logic [es2u_pkg::HOUR_W-1:0]        m_hour,
    output logic [es2u_pkg::MIN_W-1:0]         m_minute,
    output logic [es2u_pkg::SEC_W-1:0]         m_second
);

    localparam int LAT = 21;
    localparam int XW1 = EPOCH_BITS - es2u_pkg::DAY_LO_BITS;
    localparam int QW1 = $clog2(((64'd1 << XW1) - 64'd1) / es2u_pkg::DAY_DIV + 64'd1);
    localparam longint unsigned ZMAX =
        ((64'd1 << EPOCH_BITS) - 64'd1) / es2u_pkg::SEC_PER_DAY + es2u_pkg::SHIFT_DAYS;
    localparam int ZW  = $clog2(ZMAX + 64'd1);
    localparam int QW4 = $clog2(((64'd1 << ZW) - 64'd1) / es2u_pkg::DAYS_PER_CYCLE + 64'd1);
    localparam int DW  = es2u_pkg::DOC_W;
    localparam int YW  = es2u_pkg::YEAR_W;

    logic               en;
    logic [LAT:0]       v_reg;
    logic [EPOCH_BITS-1:0] in_reg;

    // time of day
    logic [QW1-1:0] days_q;
    logic [9:0]     rem1;
    logic [6:0]     lo7_d;
    logic [16:0]    sod;
    logic [5:0]     hour_q;
    logic [7:0]     rem2;
    logic [3:0]     lo4_d;
    logic [11:0]    rem_h;
    logic [6:0]     minute_q;
    logic [3:0]     rem3;
    logic [1:0]     lo2_d;
    logic [5:0]     second_w;

    // date
    logic [ZW-1:0]  z_reg;
    logic [QW4-1:0] cycle_q;
    logic [DW-1:0]  doc_q, doc10, doc15;
    logic [YW-1:0]  cyc400_reg, cyc400_d;
    logic [7:0]     q1460;
    logic [2:0]     q36524;
    logic [DW-1:0]  n_reg, n_next;
    logic [9:0]     yoc_q, yoc_d;
    logic [1:0]     c100;
    logic [DW-1:0]  yd_reg, yd_next;
    es2u_pkg::doy_t doy_reg, doy_next, doy_d;
    logic [10:0]    w_reg, w_next;
    logic [3:0]     mp_q;

    logic [YW-1:0]                    year_reg, year_next;
    logic [es2u_pkg::MONTH_W-1:0]     month_reg, month_next;
    logic [es2u_pkg::DAY_W-1:0]       day_reg, day_next;

    assign en      = m_ready | ~v_reg[LAT];
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[LAT-1:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg     <= s_epoch_seconds;
            z_reg      <= ZW'(days_q) + ZW'(es2u_pkg::SHIFT_DAYS);
            cyc400_reg <= YW'(YW'(cycle_q) * es2u_pkg::YEARS_PER_CYCLE);
            n_reg      <= n_next;
            yd_reg     <= yd_next;
            doy_reg    <= doy_next;
            w_reg      <= w_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
        end
    end

    // seconds to days and second of day
    es2u_cdiv #(.XW(XW1), .DIVISOR(es2u_pkg::DAY_DIV), .QW(QW1), .RMW(10)) u_div_day (
        .aclk(aclk), .en(en), .x_i(in_reg[EPOCH_BITS-1:es2u_pkg::DAY_LO_BITS]),
        .q_o(days_q), .rem_o(rem1)
    );
    es2u_dly #(.W(7), .N(3)) u_dly_lo7 (
        .aclk(aclk), .en(en), .d(in_reg[6:0]), .q(lo7_d)
    );
    assign sod = {rem1, lo7_d};

    es2u_cdiv #(.XW(13), .DIVISOR(es2u_pkg::HOUR_DIV), .QW(6), .RMW(8)) u_div_hour (
        .aclk(aclk), .en(en), .x_i(sod[16:4]), .q_o(hour_q), .rem_o(rem2)
    );
    es2u_dly #(.W(4), .N(3)) u_dly_lo4 (
        .aclk(aclk), .en(en), .d(sod[3:0]), .q(lo4_d)
    );
    assign rem_h = {rem2, lo4_d};

    es2u_cdiv #(.XW(10), .DIVISOR(es2u_pkg::MIN_DIV), .QW(7), .RMW(4)) u_div_min (
        .aclk(aclk), .en(en), .x_i(rem_h[11:2]), .q_o(minute_q), .rem_o(rem3)
    );
    es2u_dly #(.W(2), .N(3)) u_dly_lo2 (
        .aclk(aclk), .en(en), .d(rem_h[1:0]), .q(lo2_d)
    );
    assign second_w = {rem3, lo2_d};

    es2u_dly #(.W(es2u_pkg::HOUR_W), .N(15)) u_dly_hour (
        .aclk(aclk), .en(en), .d(hour_q[4:0]), .q(m_hour)
    );
    es2u_dly #(.W(es2u_pkg::MIN_W), .N(12)) u_dly_min (
        .aclk(aclk), .en(en), .d(minute_q[5:0]), .q(m_minute)
    );
    es2u_dly #(.W(es2u_pkg::SEC_W), .N(12)) u_dly_sec (
        .aclk(aclk), .en(en), .d(second_w), .q(m_second)
    );

    // March based day count to 400-year cycle and day of cycle
    es2u_cdiv #(.XW(ZW), .DIVISOR(es2u_pkg::DAYS_PER_CYCLE), .QW(QW4), .RMW(DW)) u_div_cyc (
        .aclk(aclk), .en(en), .x_i(z_reg), .q_o(cycle_q), .rem_o(doc_q)
    );
    es2u_dly #(.W(YW), .N(12)) u_dly_cyc (
        .aclk(aclk), .en(en), .d(cyc400_reg), .q(cyc400_d)
    );

    es2u_cdiv #(.XW(16), .DIVISOR(es2u_pkg::DAYS_PER_YEAR), .QW(8), .RMW(9)) u_div_1460 (
        .aclk(aclk), .en(en), .x_i(doc_q[DW-1:2]), .q_o(q1460), .rem_o()
    );
    es2u_cdiv #(.XW(16), .DIVISOR(es2u_pkg::DAYS_PER_CENT4), .QW(3), .RMW(14)) u_div_36524 (
        .aclk(aclk), .en(en), .x_i(doc_q[DW-1:2]), .q_o(q36524), .rem_o()
    );
    es2u_dly #(.W(DW), .N(3)) u_dly_doc10 (
        .aclk(aclk), .en(en), .d(doc_q), .q(doc10)
    );

    assign n_next = doc10 - DW'(q1460) + DW'(q36524) - DW'(doc10 == es2u_pkg::LAST_DOC);

    es2u_cdiv #(.XW(DW), .DIVISOR(es2u_pkg::DAYS_PER_YEAR), .QW(10), .RMW(9)) u_div_yoc (
        .aclk(aclk), .en(en), .x_i(n_reg), .q_o(yoc_q), .rem_o()
    );

    // year of cycle stays below 400
    assign c100 = 2'(yoc_q >= 10'd100) + 2'(yoc_q >= 10'd200) + 2'(yoc_q >= 10'd300);
    assign yd_next = DW'(DW'(yoc_q) * DW'(es2u_pkg::DAYS_PER_YEAR))
                   + DW'(yoc_q >> 2) - DW'(c100);

    es2u_dly #(.W(DW), .N(5)) u_dly_doc15 (
        .aclk(aclk), .en(en), .d(doc10), .q(doc15)
    );
    assign doy_next = 9'(doc15 - yd_reg);
    assign w_next   = 11'(11'(doy_reg) * 11'd5 + 11'd2);

    es2u_cdiv #(.XW(11), .DIVISOR(es2u_pkg::MP_DIV), .QW(4), .RMW(8)) u_div_mp (
        .aclk(aclk), .en(en), .x_i(w_reg), .q_o(mp_q), .rem_o()
    );
    es2u_dly #(.W(9), .N(4)) u_dly_doy (
        .aclk(aclk), .en(en), .d(doy_reg), .q(doy_d)
    );
    es2u_dly #(.W(10), .N(6)) u_dly_yoc (
        .aclk(aclk), .en(en), .d(yoc_q), .q(yoc_d)
    );

    // January and February belong to the next civil year
    assign day_next   = 5'(doy_d - es2u_pkg::month_start(mp_q) + 9'd1);
    assign month_next = (mp_q < es2u_pkg::MP_JAN) ? mp_q + 4'd3 : mp_q - 4'd9;
    assign year_next  = YW'(yoc_d) + cyc400_d + YW'(mp_q >= es2u_pkg::MP_JAN);

    assign m_valid        = v_reg[LAT];
    assign m_year         = year_reg;
    assign m_month        = month_reg;
    assign m_day_of_month = day_reg;

    `ES2U_ASSERT_NEXT(a_stall_hold, v_reg[LAT] && !m_ready, $stable(v_reg), "pipeline moved during stall")
    `ES2U_ASSERT_NEXT(a_take, s_valid && s_ready, v_reg[0], "accepted transfer lost")
    `ES2U_ASSERT_SAME(a_feb_len, m_valid && m_month == es2u_pkg::MONTH_FEB, m_day_of_month <= 5'd29, "February day out of range")

endmodule
